// ===== rtl/core/olist_pkg.sv =====
// Ordered list engine: shared constants, payload words, command/status structs and FSM states.
// No dependencies; imported by every module of the engine.
`default_nettype none

package olist_pkg;

	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;

	localparam int OPC_W   = 2;
	localparam int POS_W   = 9;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int LINK_W = $clog2(CAPACITY + 1);
	localparam int CNT_W  = LINK_W;
	localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	localparam int SCAN_W  = 16;
	localparam int NUM_GRP = CAPACITY / SCAN_W;
	localparam int GRP_W   = $clog2(NUM_GRP);
	localparam int ENC_W   = $clog2(SCAN_W);

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2
	} olist_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} olist_status_t;

	typedef struct packed {
		logic [OPC_W-1:0]   opcode;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
	} olist_in_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VALUE_W-1:0] removed_value;
		logic [POS_W-1:0]   found_position;
	} olist_out_t;

	typedef struct packed {
		logic          load;
		logic          stat_ld;
		olist_status_t stat;
		logic          scan;
		logic          advance;
		logic          found_ld;
		logic          wr_a;
		logic          wr_b;
		logic          finish;
	} olist_cmd_t;

	typedef struct packed {
		logic [OPC_W-1:0] op;
		logic             ins_bad;
		logic             del_bad;
		logic             full;
		logic             first_pos;
		logic             free_hit;
		logic             walk_hit;
		logic             walk_end;
	} olist_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_WALK,
		S_WRITE_A,
		S_WRITE_B,
		S_FINISH
	} olist_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/olist_dp.sv =====
// Ordered list engine datapath: value and link memories, head, count, free map, walk registers.
// Depends on olist_pkg; driven by olist_ctrl through olist_cmd_t.
`default_nettype none

module olist_dp import olist_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire olist_cmd_t  cmd,
	input  wire olist_in_t   request,
	output olist_stat_t      stat,
	output logic             done,
	output olist_out_t       result
);

	logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
	logic [LINK_W-1:0]     link_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] val_rd;
	logic [LINK_W-1:0]     link_rd;

	logic [OPC_W-1:0]      op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	olist_status_t         stat_q;
	logic [DATA_WIDTH-1:0] removed_q;
	logic [CNT_W-1:0]      found_q;
	logic [CNT_W-1:0]      k_q;
	logic [CNT_W-1:0]      count_q;
	logic                  rd_valid_q;
	logic [GRP_W-1:0]      grp_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     node_q;
	logic [SLOT_W-1:0]     prev_q;
	logic [LINK_W-1:0]     head_q;
	logic [CAPACITY-1:0]   free_q;
	logic                  done_q;
	olist_out_t            result_q;

	logic                  is_ins;
	logic                  is_loc;
	logic                  first;
	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      cnt_x;
	logic [CMP_W-1:0]      target_x;
	logic [LINK_W-1:0]     cur_link;
	logic [SCAN_W-1:0]     grp_bits;
	logic [ENC_W-1:0]      enc;
	logic [LINK_W-1:0]     next_link;
	logic                  link_we;
	logic [SLOT_W-1:0]     link_wa;
	logic [LINK_W-1:0]     link_wd;

	assign is_ins   = (op_q == OP_INSERT);
	assign is_loc   = (op_q == OP_LOCATE);
	assign first    = (pos_q == POS_W'(1));
	assign pos_x    = CMP_W'(pos_q);
	assign cnt_x    = CMP_W'(count_q);
	assign target_x = is_ins ? (pos_x - CMP_W'(1)) : pos_x;
	assign cur_link = (k_q == '0) ? head_q : link_rd;
	assign grp_bits = free_q[grp_q*SCAN_W +: SCAN_W];
	assign next_link = first ? head_q : link_rd;

	always_comb begin
		enc = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (grp_bits[i])
				enc = ENC_W'(i);
		end
	end

	always_comb begin
		stat.op        = op_q;
		stat.ins_bad   = pos_x > (cnt_x + CMP_W'(1));
		stat.del_bad   = pos_x > cnt_x;
		stat.full      = (cnt_x == CMP_W'(CAPACITY));
		stat.first_pos = first;
		stat.free_hit  = |grp_bits;
		stat.walk_hit  = is_loc ? (rd_valid_q && (val_rd == val_q))
		                        : (CMP_W'(k_q) == target_x);
		stat.walk_end  = (k_q == count_q);
	end

	assign link_we = (cmd.wr_a && (is_ins || !first)) || cmd.wr_b;
	assign link_wa = cmd.wr_b ? node_q : (is_ins ? slot_q : prev_q);
	assign link_wd = cmd.wr_b ? LINK_W'(slot_q) : (is_ins ? next_link : link_rd);

	always_ff @(posedge clk) begin
		if (cmd.wr_a && is_ins)
			val_mem[slot_q] <= val_q;
		if (cmd.advance)
			val_rd <= val_mem[cur_link[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (cmd.advance)
			link_rd <= link_mem[cur_link[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= LINK_W'(CAPACITY);
			count_q    <= '0;
			free_q     <= '1;
			k_q        <= '0;
			rd_valid_q <= 1'b0;
			grp_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				k_q        <= '0;
				rd_valid_q <= 1'b0;
				grp_q      <= '0;
			end
			if (cmd.scan && !(|grp_bits))
				grp_q <= grp_q + GRP_W'(1);
			if (cmd.advance) begin
				k_q        <= k_q + CNT_W'(1);
				rd_valid_q <= 1'b1;
			end
			if (cmd.wr_a) begin
				if (is_ins) begin
					free_q[slot_q] <= 1'b0;
					count_q        <= count_q + CNT_W'(1);
					if (first)
						head_q <= LINK_W'(slot_q);
				end else begin
					free_q[node_q] <= 1'b1;
					count_q        <= count_q - CNT_W'(1);
					if (first)
						head_q <= link_rd;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= request.opcode;
			pos_q     <= (request.position == '0) ? POS_W'(1) : request.position;
			val_q     <= request.value[DATA_WIDTH-1:0];
			stat_q    <= ST_OK;
			removed_q <= '0;
			found_q   <= '0;
		end
		if (cmd.stat_ld)
			stat_q <= cmd.stat;
		if (cmd.scan && (|grp_bits))
			slot_q <= {grp_q, enc};
		if (cmd.advance) begin
			node_q <= cur_link[SLOT_W-1:0];
			prev_q <= node_q;
		end
		if (cmd.found_ld)
			found_q <= k_q;
		if (cmd.wr_a && !is_ins)
			removed_q <= val_rd;
		if (cmd.finish) begin
			result_q.status         <= stat_q;
			result_q.removed_value  <= VALUE_W'(removed_q);
			result_q.found_position <= POS_W'(found_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/olist_ctrl.sv =====
// Ordered list engine controller: sequences check, free-slot scan, list walk and writeback.
// Depends on olist_pkg; drives olist_dp through olist_cmd_t.
`default_nettype none

module olist_ctrl import olist_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire olist_stat_t stat,
	output olist_cmd_t       cmd,
	output logic             busy
);

	olist_state_t state_q;
	olist_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.stat = ST_OK;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.ins_bad) begin
							cmd.stat_ld = 1'b1;
							cmd.stat    = ST_RANGE;
							state_d     = S_FINISH;
						end else if (stat.full) begin
							cmd.stat_ld = 1'b1;
							cmd.stat    = ST_FULL;
							state_d     = S_FINISH;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_DELETE: begin
						if (stat.del_bad) begin
							cmd.stat_ld = 1'b1;
							cmd.stat    = ST_RANGE;
							state_d     = S_FINISH;
						end else begin
							state_d = S_WALK;
						end
					end
					OP_LOCATE: state_d = S_WALK;
					default:   state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.free_hit)
					state_d = S_WALK;
			end
			S_WALK: begin
				if (stat.walk_hit) begin
					if (stat.op == OP_LOCATE) begin
						cmd.found_ld = 1'b1;
						state_d      = S_FINISH;
					end else begin
						state_d = S_WRITE_A;
					end
				end else if ((stat.op == OP_LOCATE) && stat.walk_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_WRITE_A: begin
				cmd.wr_a = 1'b1;
				if ((stat.op == OP_INSERT) && !stat.first_pos)
					state_d = S_WRITE_B;
				else
					state_d = S_FINISH;
			end
			S_WRITE_B: begin
				cmd.wr_b = 1'b1;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_engine_unit.sv =====
// Ordered list engine top level: one word in, one result word out per operation.
// A rejected or no-op word goes from the check straight to the result strobe; locate and
// delete walk the list, and insert first scans the free map by groups, then walks it.
// The link walk visits one node per cycle through the link memory read port.
// One word at a time; the next start is taken in the cycle its result is strobed.
// Reset empties the list and marks every slot free at once; no clearing pass.
`default_nettype none

module ordered_list_engine_unit import olist_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire olist_in_t  request,
	output logic            busy,
	output logic            done,
	output olist_out_t      result
);

	olist_cmd_t  cmd;
	olist_stat_t stat;

	olist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	olist_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/olist_checker.sv =====
// Ordered list engine port checker and its bind to the top level.
// Depends on olist_pkg; watches ordered_list_engine_unit ports only.
`default_nettype none

module olist_checker import olist_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire olist_in_t  request,
	input wire logic       busy,
	input wire logic       done,
	input wire olist_out_t result
);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a pending operation");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |->
			((result.removed_value == '0) && (result.found_position == '0)))
		else $error("error result carries data");

	a_found_xor_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.found_position != '0)) |-> (result.removed_value == '0))
		else $error("result reports both a position and a removed value");

endmodule

bind ordered_list_engine_unit olist_checker u_olist_checker (.*);

`default_nettype wire
